>>> hw/rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg: shared definitions for the box filter downsampler
// Widths, register indexes and the control and status bundles.
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int PIX_W          = 8;
   localparam int SUM_W          = 22;
   localparam int LANES          = 4;
   localparam int PC_W           = 13;
   localparam int COL_W          = 16;
   localparam int DIV_W          = 15;
   localparam int CNT_W          = 5;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 13;
   localparam int MAX_OUT_COLS_DEF = 4096;
   localparam int MAX_LOG2_FACTOR  = 7;

   localparam logic [PIX_W-1:0] OPAQUE = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ON   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA   = 3'd4;

   typedef struct packed {
      logic accept;
      logic clr_wr;
      logic ram_rd;
      logic ram_wr;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic dec_mem;
      logic dec_send;
      logic lat_send;
      logic lat_div;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [PIX_W-1:0] sat8(input logic [SUM_W-1:0] v);
      sat8 = (v > SUM_W'(255)) ? OPAQUE : v[PIX_W-1:0];
   endfunction

endpackage

>>> hw/rtl/box_filter_image_downsampler.sv
// ----------------------------------------------------------------------------
// box_filter_image_downsampler: power-of-two box filter image shrinker
// Averages SxS squares of RGBA pixels, or point-samples them, in raster order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_tvalid/tready    tdata: red, green, blue, alpha
//                                             tuser: 0 pixel, 1 flush
//   rsp_      out        rsp_tvalid/tready    tdata: red, green, blue, alpha
//                                             tlast: last column of a row
//   csr_      in         csr_valid/ready      csr_index, csr_data
//
// A request that touches no sum (point sampling, idle flush, column beyond
// the output) is done when taken, or goes through the output load when
// it makes a result. A summed pixel goes through the registered read and
// write back of the column sum memory, then the output load when it sends a
// full square, with the 22-step divider between for a partial column or a flush.
// After reset all MAX_OUT_COLS columns of the sum memory are cleared before the
// first request is taken. A stalled result waits in the output register;
// the next request can be taken meanwhile, but its own result waits for it.
// ----------------------------------------------------------------------------
module box_filter_image_downsampler #(
   parameter int MAX_OUT_COLS = bfd_pkg::MAX_OUT_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // red, green, blue, alpha
   input  logic                           req_tuser,   // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,   // red, green, blue, alpha
   output logic                           rsp_tlast,   // row_end
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0] csr_data
);
   import bfd_pkg::*;

   cmd_type    cmd;
   status_type st;

   // Configuration is always taken.
   assign csr_ready = 1'b1;

   bfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bfd_dp #(
      .MAX_OUT_COLS (MAX_OUT_COLS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .st         (st)
   );

`ifndef SYNTHESIS
   // A new result must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("result register overwritten");

   // The divider reports done only after it has run.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !st.div_done)
      else $error("divider done too early");

   // No result comes out of reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif
endmodule

>>> hw/rtl/bfd_ram.sv
// ----------------------------------------------------------------------------
// bfd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/bfd_div.sv
// ----------------------------------------------------------------------------
// bfd_div: four-lane restoring divider
// Divides four sums by one common divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfd_div (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [bfd_pkg::LANES-1:0][bfd_pkg::SUM_W-1:0] dividend,
   input  logic [bfd_pkg::DIV_W-1:0]                  divisor,
   output logic [bfd_pkg::LANES-1:0][bfd_pkg::SUM_W-1:0] quotient,
   output logic                                       done
);
   import bfd_pkg::*;

   logic [LANES-1:0][SUM_W-1:0] quo_ff, quo_in;
   logic [LANES-1:0][DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]            dsr_ff;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [LANES-1:0][DIV_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {rem_ff[i], quo_ff[i][SUM_W-1]};
      end
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         for (int i = 0; i < LANES; i++) begin
            if (trial[i] >= {1'b0, dsr_ff}) begin
               rem_in[i] = DIV_W'(trial[i] - {1'b0, dsr_ff});
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][DIV_W-1:0];
               quo_in[i] = {quo_ff[i][SUM_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

>>> hw/rtl/bfd_ctrl.sv
// ----------------------------------------------------------------------------
// bfd_ctrl: sequencer of the downsampler
// Clears the sum memory after reset, then steps each summed request through
// read, write back, optional divide and output load; others at most load the output.
// ----------------------------------------------------------------------------
module bfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bfd_pkg::status_type  st,
   output bfd_pkg::cmd_type     cmd
);
   import bfd_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_WRITE = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cmd.ram_rd = st.dec_mem;
               if (st.dec_mem) begin
                  state_in = S_READ;
               end else if (st.dec_send) begin
                  state_in = S_OUT;
               end
            end
         end
         S_READ: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.ram_wr = 1'b1;
            if (!st.lat_send) begin
               state_in = S_IDLE;
            end else if (st.lat_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (st.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> hw/rtl/bfd_dp.sv
// ----------------------------------------------------------------------------
// bfd_dp: datapath of the downsampler
// Configuration registers, position counters, column sum memory,
// divider and the result register.
// ----------------------------------------------------------------------------
module bfd_dp #(
   parameter int MAX_OUT_COLS = bfd_pkg::MAX_OUT_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic [bfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfd_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [31:0]                    req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [31:0]                    rsp_tdata,
   output logic                           rsp_tlast,
   input  bfd_pkg::cmd_type               cmd,
   output bfd_pkg::status_type            st
);
   import bfd_pkg::*;

   localparam int ADDR_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_OUT_COLS - 1);
   localparam logic [COL_W-1:0]  MAX_COLS  = COL_W'(MAX_OUT_COLS);
   localparam int RAM_W = LANES * SUM_W;

   // configuration
   logic [PC_W-1:0] in_width_ff, out_width_ff;
   logic [2:0]      log2_ff;
   logic            filter_ff, alpha_ff;

   // position counters
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [7:0]       rows_ff, rows_in;
   logic [COL_W-1:0] flush_ff, flush_in;
   logic [ADDR_W-1:0] clr_ff;

   // latched request
   logic [LANES-1:0][PIX_W-1:0] px_ff;
   logic [COL_W-1:0] col_ff;
   logic             send_ff, div_ff, point_ff, flush_op_ff, rend_ff;
   logic [DIV_W-1:0] dsr_ff;
   logic [3:0]       shift_ff;
   logic [LANES-1:0][SUM_W-1:0] acc_ff;

   // result register
   logic                        out_valid_ff;
   logic [LANES-1:0][PIX_W-1:0] out_data_ff, out_data_in;
   logic                        out_last_ff;

   // decode
   logic [PC_W-1:0]  iw;
   logic [COL_W-1:0] ow, ow_raw, col, fc;
   logic [2:0]       k;
   logic [7:0]       s, smask, rem;
   logic             last_px, last_f, rend, send_px, point_px;
   logic [23:0]      next_start;
   logic [15:0]      flush_div;
   logic             dec_mem, dec_send, dec_div, dec_rend;
   logic [DIV_W-1:0] dec_dsr;

   logic [RAM_W-1:0] rd_data, wr_data;
   logic [LANES-1:0][SUM_W-1:0] acc, quo;
   logic [LANES-1:0][PIX_W-1:0] addend;
   logic [ADDR_W-1:0] wr_addr;

   always_comb begin
      iw     = (in_width_ff == '0) ? PC_W'(1) : in_width_ff;
      ow_raw = (out_width_ff == '0) ? COL_W'(1) : COL_W'(out_width_ff);
      ow     = (ow_raw > MAX_COLS) ? MAX_COLS : ow_raw;
      k      = (4'(log2_ff) > 4'(MAX_LOG2_FACTOR)) ? 3'(MAX_LOG2_FACTOR) : log2_ff;
      s      = 8'(1) << k;
      smask  = s - 8'(1);
      rem    = iw[7:0] & smask;

      col        = COL_W'(pc_ff >> k);
      last_px    = pc_ff >= (iw - PC_W'(1));
      next_start = (24'(col) + 24'(1)) << k;
      rend       = (col == ow - COL_W'(1)) || (next_start >= 24'(iw));
      send_px    = (9'(rows_ff) >= 9'(smask))
                   && (((8'(pc_ff) + 8'(1)) & smask) == '0 || last_px);
      point_px   = (rows_ff == '0) && (col < ow) && ((8'(pc_ff) & smask) == '0);

      fc        = (flush_ff >= ow) ? ow - COL_W'(1) : flush_ff;
      last_f    = (fc == ow - COL_W'(1));
      flush_div = ((rem != '0) && last_f) ? (16'(rem) * 16'(rows_ff))
                                          : (16'(s) * 16'(rows_ff));

      dec_mem  = 1'b0;
      dec_send = 1'b0;
      dec_div  = 1'b0;
      dec_rend = rend;
      dec_dsr  = DIV_W'(16'(rem) << k);
      pc_in    = pc_ff;
      rows_in  = rows_ff;
      flush_in = flush_ff;

      if (req_tuser) begin
         dec_rend = last_f;
         dec_dsr  = DIV_W'(flush_div);
         if (filter_ff && (rows_ff != '0)) begin
            dec_mem  = 1'b1;
            dec_send = 1'b1;
            dec_div  = 1'b1;
            if (last_f) begin
               flush_in = '0;
               rows_in  = '0;
               pc_in    = '0;
            end else begin
               flush_in = fc + COL_W'(1);
            end
         end
      end else begin
         if (filter_ff) begin
            dec_mem  = (col < ow);
            dec_send = (col < ow) && send_px;
            dec_div  = (rem != '0) && (col == ow - COL_W'(1));
         end else begin
            dec_send = point_px;
         end
         if (last_px) begin
            pc_in   = '0;
            rows_in = ((9'(rows_ff) + 9'(1)) >= 9'(s)) ? 8'd0 : rows_ff + 8'd1;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= PC_W'(1);
         out_width_ff <= PC_W'(1);
         log2_ff      <= '0;
         filter_ff    <= 1'b1;
         alpha_ff     <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IN_WIDTH:    in_width_ff  <= csr_data;
            CSR_OUT_WIDTH:   out_width_ff <= csr_data;
            CSR_LOG2_FACTOR: log2_ff      <= csr_data[2:0];
            CSR_FILTER_ON:   filter_ff    <= csr_data[0];
            CSR_HAS_ALPHA:   alpha_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // counters and request latch
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         rows_ff  <= '0;
         flush_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.accept) begin
            pc_ff    <= pc_in;
            rows_ff  <= rows_in;
            flush_ff <= flush_in;
         end
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
      end
      if (cmd.accept) begin
         px_ff       <= req_tdata;
         col_ff      <= req_tuser ? fc : col;
         send_ff     <= dec_send;
         div_ff      <= dec_div;
         point_ff    <= !filter_ff;
         flush_op_ff <= req_tuser;
         rend_ff     <= dec_rend;
         dsr_ff      <= dec_dsr;
         shift_ff    <= {k, 1'b0};
      end
      if (cmd.ram_wr) begin
         acc_ff <= acc;
      end
   end

   // column sums: add the pixel, or clear the column when it is sent
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         addend[i] = flush_op_ff ? '0 : px_ff[i];
      end
      if (!alpha_ff) begin
         addend[LANES-1] = '0;
      end
      for (int i = 0; i < LANES; i++) begin
         acc[i] = rd_data[i*SUM_W +: SUM_W] + SUM_W'(addend[i]);
      end
      if (cmd.clr_wr) begin
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_addr = col_ff[ADDR_W-1:0];
         wr_data = send_ff ? '0 : acc;
      end
   end

   bfd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_OUT_COLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_wr || cmd.ram_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr ((req_tuser ? fc[ADDR_W-1:0] : col[ADDR_W-1:0])),
      .rd_data (rd_data)
   );

   bfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc),
      .divisor  (dsr_ff),
      .quotient (quo),
      .done     (st.div_done)
   );

   // result selection
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (point_ff) begin
            out_data_in[i] = px_ff[i];
         end else if (div_ff) begin
            out_data_in[i] = sat8(quo[i]);
         end else begin
            out_data_in[i] = sat8(acc_ff[i] >> shift_ff);
         end
      end
      if (!alpha_ff) begin
         out_data_in[LANES-1] = OPAQUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_data_ff <= out_data_in;
         out_last_ff <= rend_ff;
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_tdata   = out_data_ff;
   assign rsp_tlast   = out_last_ff;

   assign st.clr_last = (clr_ff == LAST_ADDR);
   assign st.dec_mem  = dec_mem;
   assign st.dec_send = dec_send;
   assign st.lat_send = send_ff;
   assign st.lat_div  = div_ff;
   assign st.out_free = !out_valid_ff || rsp_tready;
endmodule

>>> bench/box_filter_image_downsampler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_filter_image_downsampler_tb: self-checking bench for the downsampler
// Streams random images and flushes through the block under a range of
// widths, factors and modes. A built-in model of the column sums predicts
// every output pixel, which is checked in order as it leaves the block.
// ----------------------------------------------------------------------------
module box_filter_image_downsampler_tb;
   import bfd_pkg::*;

   typedef enum bit {OP_PIXEL = 1'b0, OP_FLUSH = 1'b1} op_type;

   typedef struct {
      op_type      op;
      logic [31:0] rgba;
   } request_type;

   typedef struct {
      logic [31:0] rgba;
      logic        row_end;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   box_filter_image_downsampler uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be driven, and output pixels still to arrive.
   request_type   pending_requests[$];
   pixel_out_type expected_pixels[$];
   int         error_count = 0;
   int unsigned cycle_count = 0;

   // Shadow copies of the configuration registers and of the block's state.
   int unsigned cfg_in_width = 1, cfg_out_width = 1, cfg_log2 = 0;
   bit          cfg_filter_on = 1'b1, cfg_has_alpha = 1'b1;
   bit [3:0][SUM_W-1:0] column_sum [4096];
   int unsigned rows_done = 0, next_column = 0, flush_column = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Reads out one column, divided or shifted, and clears its sums.
   function automatic pixel_out_type drain_column(input int unsigned col, input int unsigned div,
                                                  input int unsigned sh, input bit row_end);
      pixel_out_type res;
      int unsigned q;
      for (int i = 0; i < LANES; i++) begin
         q = (div != 0) ? column_sum[col][i] / div : column_sum[col][i] >> sh;
         res.rgba[8*i +: 8] = (q > 255) ? 8'hFF : q[7:0];
      end
      if (!cfg_has_alpha) res.rgba[31:24] = OPAQUE;
      res.row_end = row_end;
      column_sum[col] = '0;
      return res;
   endfunction

   // Advances the shadow state by one request; returns 1 when a pixel is due.
   function automatic bit downsample_step(input request_type rq, output pixel_out_type res);
      int unsigned iw, ow, k, s, rem, fc, pc, col;
      bit last_px, row_end, due;
      iw  = (cfg_in_width == 0) ? 1 : cfg_in_width;
      ow  = (cfg_out_width == 0) ? 1 : (cfg_out_width > 4096 ? 4096 : cfg_out_width);
      k   = cfg_log2;
      s   = 1 << k;
      rem = iw & (s - 1);
      due = 1'b0;
      res = '{default: '0};
      if (rq.op == OP_FLUSH) begin
         // A flush only acts on a partly filled block while filtering.
         if (!cfg_filter_on || rows_done == 0) return 1'b0;
         fc  = (flush_column >= ow) ? ow - 1 : flush_column;
         res = drain_column(fc, (rem != 0 && fc == ow - 1) ? rem * rows_done : s * rows_done,
                            0, fc == ow - 1);
         if (fc == ow - 1) begin
            flush_column = 0;
            rows_done    = 0;
            next_column  = 0;
         end else begin
            flush_column = fc + 1;
         end
         return 1'b1;
      end
      pc      = next_column;
      col     = pc >> k;
      last_px = (pc >= iw - 1);
      row_end = (col == ow - 1) || (((col + 1) << k) >= iw);
      if (cfg_filter_on) begin
         if (col < ow) begin
            for (int i = 0; i < 3; i++)
               column_sum[col][i] = column_sum[col][i] + rq.rgba[8*i +: 8];
            if (cfg_has_alpha) column_sum[col][3] = column_sum[col][3] + rq.rgba[31:24];
            if (rows_done >= s - 1 && (((pc + 1) & (s - 1)) == 0 || last_px)) begin
               // A partial last column is divided; a full square is shifted.
               if (rem != 0 && col == ow - 1) res = drain_column(col, rem * s, 0, row_end);
               else res = drain_column(col, 0, 2 * k, row_end);
               due = 1'b1;
            end
         end
      end else if (rows_done == 0 && col < ow && (pc & (s - 1)) == 0) begin
         res.rgba = rq.rgba;
         if (!cfg_has_alpha) res.rgba[31:24] = OPAQUE;
         res.row_end = row_end;
         due = 1'b1;
      end
      if (last_px) begin
         next_column = 0;
         rows_done   = (rows_done + 1 >= s) ? 0 : rows_done + 1;
      end else begin
         next_column = pc + 1;
      end
      return due;
   endfunction

   // Monitor: everything is sampled at the rising edge. Outputs are checked
   // before the request of the same edge is predicted, since no request can
   // produce its pixel in the cycle it is taken.
   bit req_taken = 1'b0;
   always @(posedge clock) begin
      pixel_out_type want, got;
      request_type   rq;
      cycle_count <= cycle_count + 1;
      req_taken   <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected pixel", rsp_tdata, 32'h0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[7:0] !== want.rgba[7:0])
                  report_mismatch("red", rsp_tdata[7:0], want.rgba[7:0]);
               if (rsp_tdata[15:8] !== want.rgba[15:8])
                  report_mismatch("green", rsp_tdata[15:8], want.rgba[15:8]);
               if (rsp_tdata[23:16] !== want.rgba[23:16])
                  report_mismatch("blue", rsp_tdata[23:16], want.rgba[23:16]);
               if (rsp_tdata[31:24] !== want.rgba[31:24])
                  report_mismatch("alpha", rsp_tdata[31:24], want.rgba[31:24]);
               if (rsp_tlast !== want.row_end)
                  report_mismatch("row end", rsp_tlast, want.row_end);
            end
         end
         if (req_tvalid && req_tready) begin
            rq.op   = op_type'(req_tuser);
            rq.rgba = req_tdata;
            if (downsample_step(rq, got)) expected_pixels.push_back(got);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IN_WIDTH:    cfg_in_width  = csr_data;
               CSR_OUT_WIDTH:   cfg_out_width = csr_data;
               CSR_LOG2_FACTOR: cfg_log2      = csr_data[2:0];
               CSR_FILTER_ON:   cfg_filter_on = csr_data[0];
               CSR_HAS_ALPHA:   cfg_has_alpha = csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Driver: bursts of requests with random gaps, and stretches with no gaps.
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      request_type rq;
      bit          stall_mode;
      if (!reset) begin
         // The receiver's readiness steps through four patterns of its own in turn.
         case ((cycle_count / 300) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= (cycle_count % 5) < 2;
            default: rsp_tready <= ($urandom_range(0, 15) == 0);
         endcase
         stall_mode = ((cycle_count / 700) % 3) != 0;
         if (!req_tvalid || req_taken) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               rq = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= rq.op;
               req_tdata  <= rq.rgba;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= stall_mode ? $urandom_range(0, 6) : 0;
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int unsigned iw, input int unsigned ow, input int unsigned k,
                            input bit filter, input bit alpha);
      write_csr(CSR_IN_WIDTH, iw);
      write_csr(CSR_OUT_WIDTH, ow);
      write_csr(CSR_LOG2_FACTOR, k);
      write_csr(CSR_FILTER_ON, filter);
      write_csr(CSR_HAS_ALPHA, alpha);
   endtask

   // Lets the block drain; pixels that send nothing may still be writing
   // their sums back, so a margin past the last request is kept before any
   // register write.
   task automatic wait_idle();
      @(posedge clock);
      while (pending_requests.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] random_rgba();
      logic [31:0] v;
      v = $urandom;
      for (int i = 0; i < LANES; i++)
         case ($urandom_range(0, 7))
            0: v[8*i +: 8] = 8'h00;
            1: v[8*i +: 8] = 8'hFF;
            default: ;
         endcase
      return v;
   endfunction

   task automatic push(input op_type op, input logic [31:0] rgba);
      pending_requests.push_back('{op, rgba});
   endtask

   int pixels_sent = 0;
   initial begin
      int unsigned iw, ow, k, rows, flushes, iw_eff;
      bit filter;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extreme pixels, an idle flush.
      push(OP_PIXEL, 32'h0000_0000);
      push(OP_PIXEL, 32'hFFFF_FFFF);
      push(OP_FLUSH, 32'hFFFF_FFFF);
      push(OP_PIXEL, 32'hA55A_3CC3);
      wait_idle();
      // Partial last column with no alpha channel, then flushes in mid-row, which send nothing.
      configure(5, 3, 1, 1'b1, 1'b0);
      for (int i = 0; i < 13; i++) push(OP_PIXEL, (i % 2) ? 32'hFFFF_FFFF : 32'h1020_3040);
      for (int i = 0; i < 4; i++) push(OP_FLUSH, 32'h0);
      wait_idle();
      // Point sampling, zero widths acting as one.
      configure(0, 0, 0, 1'b0, 1'b1);
      push(OP_PIXEL, 32'h8001_7F80);
      push(OP_FLUSH, 32'h0);
      wait_idle();
      // Widest settings and the largest factor.
      configure(8191, 8191, 7, 1'b1, 1'b1);
      for (int i = 0; i < 4; i++) push(OP_PIXEL, 32'hFFFF_FFFF);
      wait_idle();

      // Random images: whole blocks and partial ones, with stray flushes.
      while (pixels_sent < 1850) begin
         k = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 3);
         case ($urandom_range(0, 15))
            0: iw = 0;
            1: iw = 8191;
            default: iw = (k == 7) ? $urandom_range(1, 3) : $urandom_range(1, 24);
         endcase
         iw_eff = (iw == 0) ? 1 : iw;
         case ($urandom_range(0, 9))
            0: ow = 0;
            1: ow = 8191;
            2, 3: ow = $urandom_range(1, 8);
            default: ow = (iw_eff + (1 << k) - 1) >> k;
         endcase
         filter = ($urandom_range(0, 4) != 0);
         configure(iw, ow, k, filter, $urandom_range(0, 1));
         rows = $urandom_range(1, 2 * (1 << k) + 1);
         if (iw_eff * rows > 400) rows = 400 / iw_eff;
         if (rows == 0) rows = 1;
         for (int p = 0; p < iw_eff * rows && p < 400; p++) begin
            if ($urandom_range(0, 39) == 0) push(OP_FLUSH, $urandom);
            push(OP_PIXEL, random_rgba());
            pixels_sent++;
         end
         flushes = (ow == 0) ? 1 : (ow > 20 ? $urandom_range(0, 4) : ow + $urandom_range(0, 1));
         if ($urandom_range(0, 3) != 0)
            for (int f = 0; f < flushes; f++) push(OP_FLUSH, $urandom);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("box_filter_image_downsampler_tb: PASS");
      end else begin
         $display("box_filter_image_downsampler_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("box_filter_image_downsampler_tb: FAIL");
      $finish;
   end

endmodule
